// File: rtl/i2cms_pkg.sv
// shared types, command codes and delay helper for the i2c master bit sequencer
package i2cms_pkg;

    localparam int CMD_W   = 3;
    localparam int PHASE_W = 3;
    localparam int BITC_W  = 4;
    localparam int DLY_W   = 11;
    localparam int US_W    = 3;

    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAITACK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    localparam logic [0:0] REG_TICKS_PER_US = 1'd0;
    localparam logic [0:0] REG_ACK_POLL_LIM = 1'd1;

    localparam logic [US_W-1:0] US_1 = 3'd1;
    localparam logic [US_W-1:0] US_2 = 3'd2;
    localparam logic [US_W-1:0] US_5 = 3'd5;

    localparam logic [BITC_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0]        POLL_LIM_MIN  = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   active_command;
        logic [PHASE_W-1:0] phase;
        logic [BITC_W-1:0]  bit_count;
        logic [7:0]         shift_register;
        logic [DLY_W-1:0]   delay_count;
        logic [7:0]         poll_count;
        logic               scl_level;
        logic               sda_level;
        logic               sda_enable;
        logic               ack_flag;
        logic               send_ack_flag;
        logic [7:0]         rx_data;
    } state_t;

    // microseconds to ticks, at most 5 * 255 so it fits without masking
    function automatic logic [DLY_W-1:0] delay_ticks(input logic [US_W-1:0] us,
                                                     input logic [7:0] tpm);
        logic [DLY_W-1:0] wide_tpm;
        wide_tpm = {{(DLY_W-8){1'b0}}, tpm};
        return DLY_W'(wide_tpm * {{(DLY_W-US_W){1'b0}}, us});
    endfunction

    // sequencer state after reset: idle, with scl and sda driven high
    function automatic state_t reset_state();
        state_t s;
        s            = '0;
        s.scl_level  = 1'b1;
        s.sda_level  = 1'b1;
        s.sda_enable = 1'b1;
        return s;
    endfunction

endpackage

// File: rtl/i2c_master_bit_sequencer_unit.sv
// top level of the i2c master bit sequencer: item registers, state and config
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid in_ready cmd tx_byte ack_after_read sda_in | into block
//  out     | out_valid out_ready scl_out sda_out sda_drive_enable
//          | busy_res done_res rx_byte ack_received           | out of block
//  cfg     | cfg_we cfg_index cfg_data                        | into block
//
// one item per cycle sustained while the output is not stalled; each item is one
// bus tick and is stepped by the next-state logic between the input register and
// the result register, which loads when its item advances to the output.
// reset clears the sequencer state and the valid flags; config returns to
// 8 ticks per microsecond and a poll limit of 255.
// a stall on the output holds the result register and then the input register.
module i2c_master_bit_sequencer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] tx_byte,
    input  logic       ack_after_read,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_out,
    output logic       sda_out,
    output logic       sda_drive_enable,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_received,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import i2cms_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       step_done;

    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic [7:0] tx_byte_reg;
    logic       ack_after_read_reg;
    logic       sda_in_reg;

    logic       out_valid_reg;
    logic       scl_reg;
    logic       sda_reg;
    logic       sda_en_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rx_reg;
    logic       ack_reg;

    logic [7:0] tpm_reg;
    logic [7:0] poll_lim_reg;

    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    i2cms_step u_step (
        .cur                   (state_reg),
        .cmd                   (cmd_reg),
        .tx_byte               (tx_byte_reg),
        .ack_after_read        (ack_after_read_reg),
        .sda_in                (sda_in_reg),
        .ticks_per_microsecond (tpm_reg),
        .ack_poll_limit        (poll_lim_reg),
        .nxt                   (state_next),
        .done                  (step_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg      <= 8'd8;
            poll_lim_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_US: tpm_reg      <= cfg_data;
                REG_ACK_POLL_LIM: poll_lim_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= reset_state();
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg            <= cmd;
            tx_byte_reg        <= tx_byte;
            ack_after_read_reg <= ack_after_read;
            sda_in_reg         <= sda_in;
        end
        if (advance)
        begin
            scl_reg    <= state_next.scl_level;
            sda_reg    <= state_next.sda_enable ? state_next.sda_level : 1'b1;
            sda_en_reg <= state_next.sda_enable;
            busy_reg   <= state_next.active_command != CMD_NONE;
            done_reg   <= step_done;
            rx_reg     <= state_next.rx_data;
            ack_reg    <= state_next.ack_flag;
        end
    end

    assign out_valid        = out_valid_reg;
    assign scl_out          = scl_reg;
    assign sda_out          = sda_reg;
    assign sda_drive_enable = sda_en_reg;
    assign busy_res         = busy_reg;
    assign done_res         = done_reg;
    assign rx_byte          = rx_reg;
    assign ack_received     = ack_reg;

    // a finished command never reports busy in the same item
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done with busy set");

    // released sda always reads high
    a_sda_released_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_drive_enable |-> sda_out)
        else $error("sda low while not driven");

    // when idle no delay or phase is left over
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.active_command == CMD_NONE |->
            state_reg.delay_count == '0 && state_reg.phase == '0)
        else $error("idle with pending delay or phase");

    // state moves only when an item is stepped
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

endmodule

// File: rtl/i2cms_step.sv
// next-state logic for one bus tick of the sequencer
module i2cms_step (
    input  i2cms_pkg::state_t cur,
    input  logic [2:0]        cmd,
    input  logic [7:0]        tx_byte,
    input  logic              ack_after_read,
    input  logic              sda_in,
    input  logic [7:0]        ticks_per_microsecond,
    input  logic [7:0]        ack_poll_limit,
    output i2cms_pkg::state_t nxt,
    output logic              done
);
    import i2cms_pkg::*;

    localparam logic [PHASE_W-1:0] PH0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH4 = 3'd4;
    localparam logic [PHASE_W-1:0] PH5 = 3'd5;

    logic       run;
    logic [7:0] limit;
    logic [8:0] poll_plus;

    assign limit     = (ack_poll_limit == 8'd0) ? POLL_LIM_MIN : ack_poll_limit;
    assign poll_plus = {1'b0, cur.poll_count} + 9'd1;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        run  = 1'b0;
        if (cur.active_command == CMD_NONE)
        begin
            if (cmd >= CMD_START && cmd <= CMD_READ)
            begin
                nxt.active_command = cmd;
                nxt.phase          = PH0;
                nxt.bit_count      = '0;
                nxt.poll_count     = '0;
                nxt.delay_count    = '0;
                nxt.shift_register = (cmd == CMD_WRITE) ? tx_byte : 8'd0;
                nxt.send_ack_flag  = ack_after_read;
                run                = 1'b1;
            end
        end
        else if (cur.delay_count != '0)
        begin
            nxt.delay_count = cur.delay_count - 1'b1;
        end
        else
        begin
            run = 1'b1;
        end

        if (run)
        begin
            unique case (nxt.active_command)
                CMD_START:
                begin
                    unique case (nxt.phase)
                        PH0:
                        begin
                            nxt.sda_enable  = 1'b1;
                            nxt.sda_level   = 1'b1;
                            nxt.scl_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH1;
                        end
                        PH1:
                        begin
                            nxt.sda_level   = 1'b0;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH2;
                        end
                        default:
                        begin
                            nxt.scl_level      = 1'b0;
                            nxt.active_command = CMD_NONE;
                            nxt.phase          = PH0;
                            done               = 1'b1;
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    unique case (nxt.phase)
                        PH0:
                        begin
                            nxt.sda_enable  = 1'b1;
                            nxt.sda_level   = 1'b0;
                            nxt.delay_count = delay_ticks(US_1, ticks_per_microsecond);
                            nxt.phase       = PH1;
                        end
                        PH1:
                        begin
                            nxt.scl_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH2;
                        end
                        PH2:
                        begin
                            nxt.sda_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH3;
                        end
                        default:
                        begin
                            nxt.active_command = CMD_NONE;
                            nxt.phase          = PH0;
                            done               = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    unique case (nxt.phase)
                        PH1:
                        begin
                            nxt.scl_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH2;
                        end
                        PH2:
                        begin
                            nxt.scl_level   = 1'b0;
                            nxt.bit_count   = nxt.bit_count + 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH3;
                        end
                        default:
                        begin
                            if (nxt.phase != PH0 && nxt.bit_count >= BITS_PER_BYTE)
                            begin
                                nxt.active_command = CMD_NONE;
                                nxt.phase          = PH0;
                                done               = 1'b1;
                            end
                            else
                            begin
                                // put the next bit on sda, msb first
                                nxt.sda_enable  = 1'b1;
                                nxt.scl_level   = 1'b0;
                                nxt.sda_level   =
                                    nxt.shift_register[3'd7 - nxt.bit_count[2:0]];
                                nxt.delay_count = delay_ticks(US_2, ticks_per_microsecond);
                                nxt.phase       = PH1;
                            end
                        end
                    endcase
                end
                CMD_WAITACK:
                begin
                    unique case (nxt.phase)
                        PH0:
                        begin
                            nxt.sda_enable  = 1'b0;
                            nxt.sda_level   = 1'b1;
                            nxt.scl_level   = 1'b0;
                            nxt.delay_count = delay_ticks(US_1, ticks_per_microsecond);
                            nxt.phase       = PH1;
                        end
                        PH1:
                        begin
                            nxt.scl_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_1, ticks_per_microsecond);
                            nxt.phase       = PH2;
                        end
                        default:
                        begin
                            priority if (!sda_in)
                            begin
                                nxt.scl_level      = 1'b0;
                                nxt.ack_flag       = 1'b1;
                                nxt.active_command = CMD_NONE;
                                nxt.phase          = PH0;
                                done               = 1'b1;
                            end
                            else if (poll_plus >= {1'b0, limit})
                            begin
                                // timeout: first step of a stop on this same tick
                                nxt.poll_count     = '0;
                                nxt.ack_flag       = 1'b0;
                                nxt.active_command = CMD_STOP;
                                nxt.sda_enable     = 1'b1;
                                nxt.sda_level      = 1'b0;
                                nxt.delay_count    =
                                    delay_ticks(US_1, ticks_per_microsecond);
                                nxt.phase          = PH1;
                            end
                            else
                            begin
                                nxt.poll_count = poll_plus[7:0];
                            end
                        end
                    endcase
                end
                CMD_READ:
                begin
                    unique case (nxt.phase)
                        PH0:
                        begin
                            nxt.delay_count = delay_ticks(US_2, ticks_per_microsecond);
                            nxt.phase       = PH1;
                        end
                        PH1:
                        begin
                            nxt.sda_enable  = 1'b0;
                            nxt.sda_level   = 1'b1;
                            nxt.scl_level   = 1'b0;
                            nxt.delay_count = delay_ticks(US_1, ticks_per_microsecond);
                            nxt.phase       = PH2;
                        end
                        PH2:
                        begin
                            nxt.scl_level      = 1'b1;
                            nxt.shift_register = {nxt.shift_register[6:0], sda_in};
                            nxt.bit_count      = nxt.bit_count + 1'b1;
                            nxt.delay_count    = delay_ticks(US_1, ticks_per_microsecond);
                            nxt.phase          = PH3;
                        end
                        PH3:
                        begin
                            nxt.scl_level = 1'b0;
                            if (nxt.bit_count < BITS_PER_BYTE)
                            begin
                                nxt.delay_count = delay_ticks(US_1, ticks_per_microsecond);
                                nxt.phase       = PH2;
                            end
                            else
                            begin
                                nxt.rx_data     = nxt.shift_register;
                                nxt.sda_enable  = 1'b1;
                                nxt.sda_level   = ~nxt.send_ack_flag;
                                nxt.delay_count = delay_ticks(US_2, ticks_per_microsecond);
                                nxt.phase       = PH4;
                            end
                        end
                        PH4:
                        begin
                            nxt.scl_level   = 1'b1;
                            nxt.delay_count = delay_ticks(US_5, ticks_per_microsecond);
                            nxt.phase       = PH5;
                        end
                        default:
                        begin
                            nxt.scl_level      = 1'b0;
                            nxt.active_command = CMD_NONE;
                            nxt.phase          = PH0;
                            done               = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    nxt.active_command = CMD_NONE;
                    nxt.phase          = PH0;
                    done               = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: tb/i2c_master_bit_sequencer_unit_test.sv
// self-checking testbench for the i2c master bit sequencer unit
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit_test;

    import i2cms_pkg::*;

    // command codes with no defined action, treated as none
    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx;
        logic       ack;
        logic       sda;
    } bus_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } bus_levels_t;

    typedef struct packed {
        logic [2:0]  cur_cmd;
        logic [3:0]  step;
        logic [3:0]  nbits;
        logic [7:0]  shreg;
        logic [11:0] dly;
        logic [7:0]  polls;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic        acked;
        logic        ack_send;
        logic [7:0]  rx;
        logic        done;
        logic [7:0]  tpus;
        logic [7:0]  poll_lim;
    } bus_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] cmd = '0;
    logic [7:0] tx_byte = '0;
    logic       ack_after_read = 1'b0;
    logic       sda_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    bus_item_t   pending_ticks[$];
    bus_levels_t expected_levels[$];
    bus_state_t  plan_model;
    bus_state_t  bus_model;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    bit calm = 1'b0;
    int ticks_queued = 0;
    int results_seen = 0;
    int mismatches = 0;

    i2c_master_bit_sequencer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .tx_byte          (tx_byte),
        .ack_after_read   (ack_after_read),
        .sda_in           (sda_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .scl_out          (scl_out),
        .sda_out          (sda_out),
        .sda_drive_enable (sda_drive_enable),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .rx_byte          (rx_byte),
        .ack_received     (ack_received),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [11:0] us_ticks(int us, logic [7:0] tpus);
        return 12'(us * int'(tpus));
    endfunction

    // one bus tick: latch a command when idle, else count down or run the next step
    function automatic bus_state_t advance_bus(bus_state_t s, bus_item_t it);
        bit run;
        bit put;
        bit fin;
        int lim;
        run = 1'b0;
        put = 1'b0;
        fin = 1'b0;
        s.done = 1'b0;
        if (s.cur_cmd == CMD_NONE)
        begin
            if (it.cmd >= CMD_START && it.cmd <= CMD_READ)
            begin
                s.cur_cmd = it.cmd;
                s.step = '0;
                s.nbits = '0;
                s.polls = '0;
                s.dly = '0;
                s.shreg = (it.cmd == CMD_WRITE) ? it.tx : 8'd0;
                s.ack_send = it.ack;
                run = 1'b1;
            end
        end
        else if (s.dly != 0)
        begin
            s.dly = s.dly - 12'd1;
        end
        else
        begin
            run = 1'b1;
        end
        if (run)
        begin
            case (s.cur_cmd)
                CMD_START:
                    case (s.step)
                        4'd0:
                        begin
                            s.sda_en = 1'b1;
                            s.sda = 1'b1;
                            s.scl = 1'b1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd1;
                        end
                        4'd1:
                        begin
                            s.sda = 1'b0;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd2;
                        end
                        default:
                        begin
                            s.scl = 1'b0;
                            fin = 1'b1;
                        end
                    endcase
                CMD_STOP:
                    case (s.step)
                        4'd0:
                        begin
                            s.sda_en = 1'b1;
                            s.sda = 1'b0;
                            s.dly = us_ticks(1, s.tpus);
                            s.step = 4'd1;
                        end
                        4'd1:
                        begin
                            s.scl = 1'b1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd2;
                        end
                        4'd2:
                        begin
                            s.sda = 1'b1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd3;
                        end
                        default:
                            fin = 1'b1;
                    endcase
                CMD_WRITE:
                    case (s.step)
                        4'd0:
                            put = 1'b1;
                        4'd1:
                        begin
                            s.scl = 1'b1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd2;
                        end
                        4'd2:
                        begin
                            s.scl = 1'b0;
                            s.nbits = s.nbits + 4'd1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd3;
                        end
                        default:
                            if (s.nbits >= BITS_PER_BYTE)
                                fin = 1'b1;
                            else
                                put = 1'b1;
                    endcase
                CMD_WAITACK:
                    case (s.step)
                        4'd0:
                        begin
                            s.sda_en = 1'b0;
                            s.sda = 1'b1;
                            s.scl = 1'b0;
                            s.dly = us_ticks(1, s.tpus);
                            s.step = 4'd1;
                        end
                        4'd1:
                        begin
                            s.scl = 1'b1;
                            s.dly = us_ticks(1, s.tpus);
                            s.step = 4'd2;
                        end
                        default:
                        begin
                            lim = (s.poll_lim == 0) ? 1 : int'(s.poll_lim);
                            if (!it.sda)
                            begin
                                s.scl = 1'b0;
                                s.acked = 1'b1;
                                fin = 1'b1;
                            end
                            else if (int'(s.polls) + 1 >= lim)
                            begin
                                // timeout: report no ack and start a stop on this tick
                                s.polls = '0;
                                s.acked = 1'b0;
                                s.cur_cmd = CMD_STOP;
                                s.sda_en = 1'b1;
                                s.sda = 1'b0;
                                s.dly = us_ticks(1, s.tpus);
                                s.step = 4'd1;
                            end
                            else
                            begin
                                s.polls = s.polls + 8'd1;
                            end
                        end
                    endcase
                CMD_READ:
                    case (s.step)
                        4'd0:
                        begin
                            s.dly = us_ticks(2, s.tpus);
                            s.step = 4'd1;
                        end
                        4'd1:
                        begin
                            s.sda_en = 1'b0;
                            s.sda = 1'b1;
                            s.scl = 1'b0;
                            s.dly = us_ticks(1, s.tpus);
                            s.step = 4'd2;
                        end
                        4'd2:
                        begin
                            s.scl = 1'b1;
                            s.shreg = {s.shreg[6:0], it.sda};
                            s.nbits = s.nbits + 4'd1;
                            s.dly = us_ticks(1, s.tpus);
                            s.step = 4'd3;
                        end
                        4'd3:
                        begin
                            s.scl = 1'b0;
                            if (s.nbits < BITS_PER_BYTE)
                            begin
                                s.dly = us_ticks(1, s.tpus);
                                s.step = 4'd2;
                            end
                            else
                            begin
                                s.rx = s.shreg;
                                s.sda_en = 1'b1;
                                s.sda = s.ack_send ? 1'b0 : 1'b1;
                                s.dly = us_ticks(2, s.tpus);
                                s.step = 4'd4;
                            end
                        end
                        4'd4:
                        begin
                            s.scl = 1'b1;
                            s.dly = us_ticks(5, s.tpus);
                            s.step = 4'd5;
                        end
                        default:
                        begin
                            s.scl = 1'b0;
                            fin = 1'b1;
                        end
                    endcase
                default:
                    fin = 1'b1;
            endcase
            if (put)
            begin
                s.sda_en = 1'b1;
                s.scl = 1'b0;
                s.sda = s.shreg[3'd7 - s.nbits[2:0]];
                s.dly = us_ticks(2, s.tpus);
                s.step = 4'd1;
            end
            if (fin)
            begin
                s.cur_cmd = CMD_NONE;
                s.step = '0;
                s.done = 1'b1;
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, bus_levels_t got, bus_levels_t want);
        mismatches++;
        $display("mismatch on %s at result %0d: got %h, want %h",
                 what, results_seen, got, want);
    endtask

    // drive side: new item at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : driver
        bus_item_t it;
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 31) == 0)
            begin
                gap_left = $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else if (pending_ticks.size() > 0)
            begin
                it = pending_ticks.pop_front();
                cmd <= it.cmd;
                tx_byte <= it.tx;
                ack_after_read <= it.ack;
                sda_in <= it.sda;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receive side: random stalls plus one long hold to back up the pipeline
    always @(negedge clk)
    begin : receiver
        int stall_left;
        bit long_hold_done;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 1000 && pending_ticks.size() > 16)
        begin
            long_hold_done = 1'b1;
            stall_left = 300;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 31) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        bus_levels_t want;
        bus_levels_t got;
        in_fire = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (in_fire)
        begin
            bus_model = advance_bus(bus_model, {cmd, tx_byte, ack_after_read, sda_in});
            want.scl = bus_model.scl;
            want.sda = bus_model.sda_en ? bus_model.sda : 1'b1;
            want.sda_en = bus_model.sda_en;
            want.busy = (bus_model.cur_cmd != CMD_NONE);
            want.done = bus_model.done;
            want.rx = bus_model.rx;
            want.ack = bus_model.acked;
            expected_levels.push_back(want);
        end
        if (out_fire)
        begin
            got = {scl_out, sda_out, sda_drive_enable, busy_res, done_res, rx_byte,
                   ack_received};
            if (expected_levels.size() == 0)
            begin
                report_mismatch("result with no pending item", got, '0);
            end
            else
            begin
                want = expected_levels.pop_front();
                if (got !== want)
                    report_mismatch("result levels", got, want);
            end
            results_seen++;
        end
    end

    task automatic queue_tick(bus_item_t it);
        pending_ticks.push_back(it);
        plan_model = advance_bus(plan_model, it);
        ticks_queued++;
    endtask

    // a command item, then filler ticks until the sequencer is idle again;
    // in wait-ack the slave pulls sda low once ack_at high polls have passed
    task automatic send_command(logic [2:0] c, logic [7:0] tx, bit ack, int ack_at, bit noisy);
        bus_item_t it;
        it.cmd = c;
        it.tx = tx;
        it.ack = ack;
        it.sda = 1'($urandom_range(0, 1));
        queue_tick(it);
        while (plan_model.cur_cmd != CMD_NONE)
        begin
            it.cmd = 3'($urandom_range(0, 7));
            it.tx = 8'($urandom);
            it.ack = 1'($urandom_range(0, 1));
            if (!noisy && plan_model.cur_cmd == CMD_WAITACK && plan_model.step == 4'd2)
                it.sda = (int'(plan_model.polls) >= ack_at) ? 1'b0 : 1'b1;
            else
                it.sda = 1'($urandom_range(0, 1));
            queue_tick(it);
        end
    endtask

    // mostly acks within the limit, sometimes a timeout
    function automatic int ack_delay();
        int lim;
        lim = (plan_model.poll_lim == 0) ? 1 : int'(plan_model.poll_lim);
        if ($urandom_range(0, 3) == 0)
            return lim + $urandom_range(0, 5);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic run_transfer();
        int n;
        send_command(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), 0, 1'b0);
        send_command(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0, 1'b0);
        send_command(CMD_WAITACK, 8'($urandom), 1'($urandom_range(0, 1)), ack_delay(), 1'b0);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_command(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 0, 1'b0);
                send_command(CMD_WAITACK, 8'($urandom), 1'($urandom_range(0, 1)),
                             ack_delay(), 1'b0);
            end
            else
            begin
                send_command(CMD_READ, 8'($urandom), (k < n - 1), 0, 1'b0);
            end
        end
        // now and then leave the bus without a stop
        if ($urandom_range(0, 7) != 0)
            send_command(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0, 1'b0);
    endtask

    task automatic wait_for_bus_results();
        while (results_seen != ticks_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        wait_for_bus_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TICKS_PER_US)
        begin
            plan_model.tpus = val;
            bus_model.tpus = val;
        end
        else
        begin
            plan_model.poll_lim = val;
            bus_model.poll_lim = val;
        end
    endtask

    task automatic set_timing(logic [7:0] tpus, logic [7:0] lim);
        write_reg(REG_TICKS_PER_US, tpus);
        write_reg(REG_ACK_POLL_LIM, lim);
    endtask

    initial
    begin : stimulus
        logic [7:0] tpus;
        logic [7:0] lim;
        plan_model = '0;
        plan_model.scl = 1'b1;
        plan_model.sda = 1'b1;
        plan_model.sda_en = 1'b1;
        plan_model.tpus = 8'd8;
        plan_model.poll_lim = 8'd255;
        bus_model = plan_model;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at the reset timing first
        send_command(CMD_NONE, 8'h00, 1'b0, 0, 1'b1);
        send_command(CMD_UNDEF_LO, 8'hFF, 1'b1, 0, 1'b1);
        send_command(CMD_UNDEF_HI, 8'h5A, 1'b0, 0, 1'b1);
        send_command(CMD_START, 8'h00, 1'b0, 0, 1'b0);

        // smallest poll limit: a single high sample times out
        set_timing(8'd1, 8'd1);
        send_command(CMD_WAITACK, 8'h00, 1'b0, 255, 1'b0);
        send_command(CMD_WAITACK, 8'h00, 1'b0, 0, 1'b0);

        // largest poll limit: the poll count runs up to 254, then a timeout
        set_timing(8'd1, 8'd255);
        send_command(CMD_WAITACK, 8'h00, 1'b0, 300, 1'b0);

        // slowest bus
        set_timing(8'd255, 8'd2);
        send_command(CMD_WAITACK, 8'h00, 1'b0, 0, 1'b0);

        // a short transfer with both read acknowledges
        set_timing(8'd1, 8'd40);
        send_command(CMD_WRITE, 8'hFF, 1'b0, 0, 1'b0);
        send_command(CMD_WAITACK, 8'h00, 1'b0, 10, 1'b0);
        send_command(CMD_READ, 8'h00, 1'b1, 0, 1'b0);
        send_command(CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
        send_command(CMD_STOP, 8'h00, 1'b0, 0, 1'b0);

        // random transfers over a spread of timings, no idling in the last stretch
        for (int ph = 0; ph < 3; ph++)
        begin
            tpus = 8'($urandom_range(1, 2));
            lim = 8'($urandom_range(4, 40));
            set_timing(tpus, lim);
            calm = (ph == 2);
            while (ticks_queued < 1300 + ph * 150)
            begin
                if ($urandom_range(0, 3) == 0)
                    run_transfer();
                else
                    send_command(3'($urandom_range(0, 7)), 8'($urandom),
                                 1'($urandom_range(0, 1)), ack_delay(),
                                 ($urandom_range(0, 1) == 0));
            end
        end

        wait_for_bus_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
